### sv/ldt_pkg.sv
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared types, widths and helpers for the loaded dice table builder.
// ----------------------------------------------------------------------------
package ldt_pkg;

	localparam int MAX_OUTCOMES = 256;
	localparam int WEIGHT_BITS  = 20;
	localparam int ADDR_W       = $clog2(MAX_OUTCOMES);
	localparam int CNT_W        = $clog2(MAX_OUTCOMES + 2);
	localparam int TOTAL_W      = 21;
	localparam int LVL_W        = 5;
	localparam int REJ_W        = TOTAL_W + 1;
	localparam int COL_W        = 5;
	localparam int CFG_IDX_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TOTAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTCOME_COUNT = 2'd1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_COUNT = 2'd1,
		OP_ENTRY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [ADDR_W-1:0]      position;
		logic [WEIGHT_BITS-1:0] weight;
		logic [COL_W-1:0]       column;
		logic [CNT_W-1:0]       rank;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] column_count;
		logic [CNT_W-1:0] outcome_label;
		logic             found;
		logic [LVL_W-1:0] level_count;
	} out_t;

	// derived settings handed from the register block to the sequencer
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [REJ_W-1:0] reject;
		logic [CNT_W-1:0] n_used;
	} cfg_t;

	// ceiling of log2, zero for zero
	function automatic logic [LVL_W-1:0] ceil_lg(input logic [TOTAL_W-1:0] v);
		logic [LVL_W-1:0] msb;
		logic             pow2;
		msb = '0;
		for (int i = 0; i < TOTAL_W; i++) begin
			if (v[i]) msb = LVL_W'(i);
		end
		pow2 = ((v & (v - TOTAL_W'(1))) == '0);
		return pow2 ? msb : msb + LVL_W'(1);
	endfunction

endpackage

### sv/ldt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ldt_cfg_regs
// Configuration registers; derives level count, reject weight and the
// saturated outcome count when a register is written.
// ----------------------------------------------------------------------------
module ldt_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ldt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldt_pkg::TOTAL_W-1:0]    cfg_data,
	output ldt_pkg::cfg_t                  cfg
);
	import ldt_pkg::*;

	logic [LVL_W-1:0] level_q;
	logic [REJ_W-1:0] reject_q;
	logic [CNT_W-1:0] n_used_q;
	logic [LVL_W-1:0] level_d;
	logic [CNT_W-1:0] cnt_data;

	// derived values of the incoming data word
	assign level_d  = ceil_lg(cfg_data);
	assign cnt_data = cfg_data[CNT_W-1:0];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			reject_q <= REJ_W'(1);
			n_used_q <= CNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WEIGHT_TOTAL) begin
				level_q  <= level_d;
				reject_q <= (REJ_W'(1) << level_d) - REJ_W'(cfg_data);
			end else if (cfg_index == CFG_OUTCOME_COUNT) begin
				n_used_q <= (cnt_data > CNT_W'(MAX_OUTCOMES)) ? CNT_W'(MAX_OUTCOMES) : cnt_data;
			end
		end
	end

	assign cfg.level  = level_q;
	assign cfg.reject = reject_q;
	assign cfg.n_used = n_used_q;

endmodule

### sv/loaded_dice_table_builder.sv
// ----------------------------------------------------------------------------
// loaded_dice_table_builder
// Weight store and column scanner for the loaded dice roller tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one operation per
//   transaction: a weight write, a column count query or a table entry query.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result transaction for each input transaction, in order.
//   Configuration (cfg_we / cfg_index / cfg_data) sets weight_total and
//   outcome_count; write it only while no operation is in flight.
// Timing:
//   A weight write, an unused opcode or a column at or beyond the level count
//   goes straight to the done state. A query scans the first n weight store
//   entries one entry per cycle through its single registered read port, n
//   being the saturated outcome count (up to 256), then tests the reject weight.
//   in_stall is high from acceptance until the result is loaded into the
//   output register; one operation is processed at a time.
// Reset:
//   Sets the level count to 0, the reject weight to 1 and outcome_count to 1. The weight
//   store is not cleared; query only entries that have been written.
// Stall:
//   A held result stays on out_data; the next operation may be accepted and
//   worked on, but its result waits until the output register is free.
// ----------------------------------------------------------------------------
module loaded_dice_table_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ldt_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ldt_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [ldt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ldt_pkg::TOTAL_W-1:0]   cfg_data
);
	import ldt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REJECT,
		S_DONE
	} state_t;

	cfg_t                   cfg;
	state_t                 state_q;
	logic                   accept;
	logic                   is_query;
	logic [WEIGHT_BITS-1:0] mem_q [MAX_OUTCOMES];
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic [CNT_W-1:0]       addr_q;
	logic [ADDR_W-1:0]      eidx_q;
	logic                   eval_q;
	logic [COL_W-1:0]       bit_q;
	logic                   entry_op_q;
	logic [CNT_W-1:0]       rank_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       label_q;
	logic                   found_q;
	logic                   out_valid_q;
	out_t                   out_q;
	logic [REJ_W-1:0]       rdata_wide;
	logic                   hit_entry;
	logic                   hit_reject;
	logic                   out_free;

	ldt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign is_query = ((in_data.opcode == OP_COUNT) || (in_data.opcode == OP_ENTRY))
		&& (in_data.column < cfg.level);

	// bit test of the entry under scan and of the reject weight
	assign rdata_wide = REJ_W'(rdata_q);
	assign hit_entry  = rdata_wide[bit_q];
	assign hit_reject = cfg.reject[bit_q];

	// weight store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && (in_data.opcode == OP_WRITE)) begin
			mem_q[in_data.position] <= in_data.weight;
		end
		rdata_q <= mem_q[addr_q[ADDR_W-1:0]];
	end

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			addr_q      <= '0;
			eidx_q      <= '0;
			eval_q      <= 1'b0;
			bit_q       <= '0;
			entry_op_q  <= 1'b0;
			rank_q      <= '0;
			count_q     <= '0;
			label_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q     <= '0;
						eval_q     <= 1'b0;
						count_q    <= '0;
						label_q    <= '0;
						found_q    <= 1'b0;
						bit_q      <= COL_W'(cfg.level - LVL_W'(1) - LVL_W'(in_data.column));
						entry_op_q <= (in_data.opcode == OP_ENTRY);
						rank_q     <= in_data.rank;
						state_q    <= is_query ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					// evaluate the entry read last cycle
					if (eval_q && hit_entry) begin
						if (entry_op_q && (count_q == rank_q)) begin
							label_q <= CNT_W'(eidx_q);
							found_q <= 1'b1;
						end
						count_q <= count_q + CNT_W'(1);
					end
					// issue the next read or move on to the reject
					if (addr_q != cfg.n_used) begin
						eidx_q <= addr_q[ADDR_W-1:0];
						addr_q <= addr_q + CNT_W'(1);
						eval_q <= 1'b1;
					end else begin
						eval_q  <= 1'b0;
						state_q <= S_REJECT;
					end
				end
				S_REJECT: begin
					if (hit_reject) begin
						if (entry_op_q && (count_q == rank_q)) begin
							label_q <= cfg.n_used + CNT_W'(1);
							found_q <= 1'b1;
						end
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q.column_count  <= count_q;
						out_q.outcome_label <= label_q;
						out_q.found         <= found_q;
						out_q.level_count   <= cfg.level;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the loaded dice table builder. Weight writes,
// column count queries and entry lookups are fed through the valid/stall
// input channel under a range of weight totals and outcome counts. An
// internal table predictor works out each answer on acceptance and every
// result is compared field by field, in order, against those answers.
// ----------------------------------------------------------------------------
module tb_top;
	import ldt_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int ITEM_GOAL   = 1750;
	localparam int LONG_HOLD   = 1500;
	localparam int TAIL_CYCLES = 300;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TOTAL_W-1:0]   cfg_data  = '0;

	// predictor state
	logic [WEIGHT_BITS-1:0] weight_mem [MAX_OUTCOMES];
	logic [TOTAL_W-1:0]     model_total    = TOTAL_W'(1);
	logic [CNT_W-1:0]       model_outcomes = CNT_W'(1);
	bit                     filled [MAX_OUTCOMES];

	in_t  pending_ops [$];
	out_t answers_due [$];
	out_t oldest;

	logic in_taken     = 1'b0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	int   hold_left    = 0;
	bit   hold_request = 1'b0;
	bit   hold_done    = 1'b0;
	bit   calm         = 1'b0;

	int mismatches = 0;
	int queued     = 0;
	int cycles     = 0;
	int phase      = 0;
	int n_writes   = 0;
	int n_counts   = 0;
	int n_lookups  = 0;
	int n_found    = 0;

	loaded_dice_table_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// smallest k with 2^k >= total, zero for totals of 0 and 1
	function automatic int level_of(logic [TOTAL_W-1:0] total);
		int lg;
		lg = 0;
		while ((longint'(1) << lg) < longint'(total)) lg++;
		return lg;
	endfunction

	// answer of the table for one operation against the current weights
	function automatic out_t table_answer(in_t item);
		out_t             res;
		int               lvl;
		int               used;
		int               bitpos;
		int               tally;
		logic [REJ_W-1:0] spare;
		res    = '0;
		lvl    = level_of(model_total);
		spare  = (REJ_W'(1) << lvl) - REJ_W'(model_total);
		used   = (model_outcomes > MAX_OUTCOMES) ? MAX_OUTCOMES : int'(model_outcomes);
		tally  = 0;
		res.level_count = LVL_W'(lvl);
		if ((item.opcode == OP_COUNT || item.opcode == OP_ENTRY) && int'(item.column) < lvl) begin
			bitpos = lvl - 1 - int'(item.column);
			for (int i = 0; i < used; i++) begin
				if (((32'(weight_mem[i]) >> bitpos) & 32'd1) != 0) begin
					if (item.opcode == OP_ENTRY && tally == int'(item.rank)) begin
						res.outcome_label = CNT_W'(i);
						res.found         = 1'b1;
					end
					tally++;
				end
			end
			// reject outcome sits after every real one
			if (spare[bitpos]) begin
				if (item.opcode == OP_ENTRY && tally == int'(item.rank)) begin
					res.outcome_label = CNT_W'(used + 1);
					res.found         = 1'b1;
				end
				tally++;
			end
			res.column_count = CNT_W'(tally);
		end
		return res;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] draw_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return WEIGHT_BITS'(1) << $urandom_range(0, WEIGHT_BITS - 1);
			default: return WEIGHT_BITS'($urandom) >> $urandom_range(0, WEIGHT_BITS - 1);
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_op(opcode_t op, int pos, int wgt, int col, int rnk);
		in_t item;
		item.opcode   = op;
		item.position = ADDR_W'(pos);
		item.weight   = WEIGHT_BITS'(wgt);
		item.column   = COL_W'(col);
		item.rank     = CNT_W'(rnk);
		if (op == OP_WRITE) filled[item.position] = 1'b1;
		pending_ops.push_back(item);
		queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			CFG_WEIGHT_TOTAL:  model_total    = value;
			CFG_OUTCOME_COUNT: model_outcomes = value[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// block is idle once nothing is queued, offered or owed
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_ops.size() != 0 || in_valid || answers_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// input driver: a new transaction once the last one is taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ops.size() != 0) begin
				in_data  <= pending_ops.pop_front();
				in_valid <= 1'b1;
				gap_left <= calm ? 0 : idle_length();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, with one long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= idle_length();
		end
	end

	// monitor: check results against the oldest answer, predict on acceptance
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t  unexpected result: expected none, actual %h", $time, out_data);
					mismatches++;
				end else begin
					oldest = answers_due.pop_front();
					check_field("column_count", 32'(oldest.column_count),
					            32'(out_data.column_count));
					check_field("outcome_label", 32'(oldest.outcome_label),
					            32'(out_data.outcome_label));
					check_field("found", 32'(oldest.found), 32'(out_data.found));
					check_field("level_count", 32'(oldest.level_count),
					            32'(out_data.level_count));
					if (out_data.found === 1'b1) n_found++;
				end
			end
			if (in_valid && !in_stall) begin
				answers_due.push_back(table_answer(in_data));
				case (in_data.opcode)
					OP_WRITE: begin
						weight_mem[in_data.position] = in_data.weight;
						n_writes++;
					end
					OP_COUNT: n_counts++;
					OP_ENTRY: n_lookups++;
					default: ;
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [TOTAL_W-1:0] total;
		logic [CNT_W-1:0]   outcomes_set;
		int                 used;
		int                 lvl;
		int                 burst;
		int                 roll;
		int                 col;
		int                 rnk;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no levels, so nothing is scanned
		queue_op(OP_COUNT, $urandom, $urandom, 0, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 0, 0);
		queue_op(OP_WRITE, 0, 20'hFFFFF, $urandom, $urandom);
		queue_op(OP_WRITE, 255, 0, $urandom, $urandom);
		queue_op(OP_NONE, $urandom, $urandom, $urandom, $urandom);
		wait_idle();

		// zero weight total and zero outcomes, plus a write to a spare index
		write_reg(CFG_WEIGHT_TOTAL, '0);
		write_reg(CFG_OUTCOME_COUNT, '0);
		write_reg(CFG_UNUSED, '1);
		queue_op(OP_COUNT, $urandom, $urandom, 0, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 0, 0);
		wait_idle();

		// only the reject outcome present: total 13 leaves reject weight 3
		write_reg(CFG_WEIGHT_TOTAL, TOTAL_W'(13));
		queue_op(OP_COUNT, $urandom, $urandom, 0, 0);
		queue_op(OP_COUNT, $urandom, $urandom, 3, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 2, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 3, 1);
		wait_idle();

		// widest total, four outcomes, junk above the count register width
		write_reg(CFG_WEIGHT_TOTAL, '1);
		write_reg(CFG_OUTCOME_COUNT, TOTAL_W'(21'h1FFE04));
		queue_op(OP_WRITE, 0, 20'hFFFFF, $urandom, $urandom);
		queue_op(OP_WRITE, 1, 20'h00000, $urandom, $urandom);
		queue_op(OP_WRITE, 2, 20'h55555, $urandom, $urandom);
		queue_op(OP_WRITE, 3, 20'hAAAAA, $urandom, $urandom);
		queue_op(OP_COUNT, $urandom, $urandom, 0, 0);
		queue_op(OP_COUNT, $urandom, $urandom, 20, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 20, 2);
		queue_op(OP_ENTRY, $urandom, $urandom, 20, 3);
		queue_op(OP_ENTRY, $urandom, $urandom, 1, 511);
		queue_op(OP_COUNT, $urandom, $urandom, 21, 0);
		queue_op(OP_ENTRY, $urandom, $urandom, 31, 0);
		wait_idle();

		// random settings, each filled before it is queried
		while (queued < ITEM_GOAL) begin
			phase++;
			case ($urandom_range(0, 9))
				0: total = TOTAL_W'($urandom_range(0, 2));
				1: total = TOTAL_W'(1) << $urandom_range(0, 20);
				2: total = '1;
				default: total = TOTAL_W'($urandom) >> $urandom_range(0, 18);
			endcase
			if (phase == 4) outcomes_set = CNT_W'(MAX_OUTCOMES);
			else if (phase == 7) outcomes_set = CNT_W'($urandom_range(257, 511));
			else begin
				case ($urandom_range(0, 19))
					0: outcomes_set = '0;
					1: outcomes_set = CNT_W'(MAX_OUTCOMES);
					2: outcomes_set = CNT_W'($urandom_range(257, 511));
					3, 4, 5: outcomes_set = CNT_W'($urandom_range(9, 64));
					default: outcomes_set = CNT_W'($urandom_range(1, 8));
				endcase
			end
			write_reg(CFG_WEIGHT_TOTAL, total);
			write_reg(CFG_OUTCOME_COUNT, TOTAL_W'(outcomes_set));
			calm = ($urandom_range(0, 4) == 0);
			// receiver holds off while the sender keeps offering
			if (phase == 2) begin
				calm         = 1'b1;
				hold_request = 1'b1;
			end
			used = (outcomes_set > MAX_OUTCOMES) ? MAX_OUTCOMES : int'(outcomes_set);
			lvl  = level_of(model_total);

			for (int i = 0; i < used; i++)
				if (!filled[i]) queue_op(OP_WRITE, i, draw_weight(), $urandom, $urandom);

			// now and then a fresh table and a sweep over every column
			if (used <= 64 && $urandom_range(0, 2) == 0) begin
				for (int i = 0; i < used; i++)
					queue_op(OP_WRITE, i, draw_weight(), $urandom, $urandom);
				for (int j = 0; j < lvl; j++) begin
					queue_op(OP_COUNT, $urandom, $urandom, j, $urandom);
					queue_op(OP_ENTRY, $urandom, $urandom, j, $urandom_range(0, used + 1));
				end
			end

			burst = (used > 64) ? 20 : $urandom_range(30, 70);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				col  = (lvl > 0 && $urandom_range(0, 5) != 0) ?
				       $urandom_range(0, lvl - 1) : $urandom_range(0, 31);
				rnk  = ($urandom_range(0, 3) != 0) ?
				       $urandom_range(0, used + 1) : $urandom_range(0, 511);
				if (roll < 20 && used > 0)
					queue_op(OP_WRITE, $urandom_range(0, used - 1), draw_weight(), col, rnk);
				else if (roll < 30)
					queue_op(OP_WRITE, $urandom_range(0, 255), draw_weight(), col, rnk);
				else if (roll < 60)
					queue_op(OP_COUNT, $urandom, $urandom, col, rnk);
				else if (roll < 95)
					queue_op(OP_ENTRY, $urandom, $urandom, col, rnk);
				else
					queue_op(OP_NONE, $urandom, $urandom, col, rnk);
			end
			wait_idle();
		end

		calm = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (answers_due.size() != 0) begin
			$display("%0t  %0d results never arrived", $time, answers_due.size());
			mismatches++;
		end

		$display("Run covered %0d transactions over %0d random settings plus directed cases:",
		         queued, phase);
		$display("  %0d weight writes, %0d column counts, %0d entry lookups (%0d entries found)",
		         n_writes, n_counts, n_lookups, n_found);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
sv/ldt_pkg.sv
sv/ldt_cfg_regs.sv
sv/loaded_dice_table_builder.sv
bench/tb_top.sv
